@@ sv/sensor_packet_filter_decode_defines.svh @@
// ----------------------------------------------------------------------------
// sensor packet filter decode assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SENSOR_PACKET_FILTER_DECODE_DEFINES_SVH
`define SENSOR_PACKET_FILTER_DECODE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SPFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SPFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPFD_ASSERT_IMP(lbl, ante, cons, msg)
`define SPFD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ sv/spfd_pkg.sv @@
// ----------------------------------------------------------------------------
// spfd_pkg
// shared types, constants and helpers of the packet filter and decoder
// ----------------------------------------------------------------------------
package spfd_pkg;

  // default number of channel offset entries
  localparam int CHANNEL_COUNT_DEF = 4;

  // register indexes of the configuration port
  localparam logic REG_WANTED_TX = 1'b0;

  // offsets loaded at reset for channels 0..3
  localparam logic [7:0] OFFSET_SEED [4] = '{8'hCE, 8'hD5, 8'hE6, 8'hE5};

  // id that never matches a normalized sequence id
  localparam logic [6:0] SEQ_NONE = 7'd64;

  // dbm conversion offset
  localparam logic signed [8:0] DBM_OFFSET = 9'sd73;

  // packet status codes
  typedef enum logic [1:0] {
    ST_CRC_FAIL  = 2'd0,
    ST_OTHER_TX  = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_ACCEPTED  = 2'd3
  } status_t;

  // reverse the bit order of a byte
  function automatic logic [7:0] flip8(input logic [7:0] b);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[7 - k] = b[k];
    end
    return r;
  endfunction

endpackage

@@ sv/sensor_packet_filter_decode.sv @@
// an accepted item reaches out_* through the input register, then the result register
// throughput: one item per cycle unless out_stall holds the output; per-channel
//   offset and last id update in the same cycle the item enters the result register
// reset (rst_n low, synchronous): pipeline empties, offsets reload CE D5 E6 E5,
//   last id returns to none, wanted transmitter returns to zero (any)
// ----------------------------------------------------------------------------
// sensor_packet_filter_decode
// filters received radio packets by crc, transmitter and repeat id, tracks the
// frequency offset of each channel and decodes readings and signal strength
// ----------------------------------------------------------------------------
`include "sensor_packet_filter_decode_defines.svh"

module sensor_packet_filter_decode
  import spfd_pkg::*;
#(
  parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_channel,
  input  logic               in_crc_ok,
  input  logic signed [7:0]  in_freq_estimate,
  input  logic [31:0]        in_source_address,
  input  logic [7:0]         in_sequence_byte,
  input  logic [15:0]        in_raw_code,
  input  logic [15:0]        in_filtered_code,
  input  logic [7:0]         in_battery_level,
  input  logic signed [7:0]  in_signal_raw,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [7:0]         out_channel_offset,
  output logic [19:0]        out_raw_value,
  output logic [20:0]        out_filtered_value,
  output logic [7:0]         out_battery_out,
  output logic signed [8:0]  out_signal_dbm,
  output logic [5:0]         out_sequence_id,
  // configuration port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  // input register
  logic               s1_valid_r;
  logic [1:0]         s1_channel_r;
  logic               s1_crc_ok_r;
  logic [7:0]         s1_freq_r;
  logic [31:0]        s1_source_r;
  logic [7:0]         s1_seq_r;
  logic [15:0]        s1_raw_code_r;
  logic [15:0]        s1_fil_code_r;
  logic [7:0]         s1_battery_r;
  logic signed [7:0]  s1_signal_r;

  // state
  logic [7:0]         offset_r [CHANNEL_COUNT];
  logic [6:0]         last_seq_r;
  logic [31:0]        wanted_tx_r;

  // result register
  logic               out_valid_r;
  status_t            out_status_r;
  logic [7:0]         out_offset_r;
  logic [19:0]        out_raw_r;
  logic [20:0]        out_fil_r;
  logic [7:0]         out_battery_r;
  logic signed [8:0]  out_dbm_r;
  logic [5:0]         out_seq_id_r;

  // per-item combinational results
  logic               advance;
  logic               in_take;
  logic               upd;
  logic               ch_ok;
  logic [7:0]         offset_cur;
  logic [7:0]         offset_sum;
  logic [7:0]         seq_diff;
  logic [5:0]         seq_id;
  logic               tx_match;
  status_t            status_c;
  logic [7:0]         offset_res;
  logic signed [8:0]  sig_ext;
  logic signed [8:0]  sig_half;
  logic signed [8:0]  dbm_c;
  logic [19:0]        raw_dec;
  logic [20:0]        fil_dec;
  logic               cfg_wr;

  // handshake: result register frees when empty or taken
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;
  assign upd      = s1_valid_r && advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    if (in_take) begin
      s1_channel_r  <= in_channel;
      s1_crc_ok_r   <= in_crc_ok;
      s1_freq_r     <= in_freq_estimate;
      s1_source_r   <= in_source_address;
      s1_seq_r      <= in_sequence_byte;
      s1_raw_code_r <= in_raw_code;
      s1_fil_code_r <= in_filtered_code;
      s1_battery_r  <= in_battery_level;
      s1_signal_r   <= in_signal_raw;
    end
  end

  // channel lookup
  assign ch_ok = {3'd0, s1_channel_r} < 5'(CHANNEL_COUNT);

  always_comb begin
    offset_cur = '0;
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      if (5'(i) == {3'd0, s1_channel_r}) begin
        offset_cur = offset_r[i];
      end
    end
  end

  assign offset_sum = offset_cur + s1_freq_r;

  // sequence id normalization
  assign seq_diff = s1_seq_r - {6'd0, s1_channel_r};
  assign seq_id   = seq_diff[7:2];

  assign tx_match = (wanted_tx_r == '0) || (s1_source_r == wanted_tx_r);

  // packet status and reported offset
  always_comb begin
    status_c   = ST_CRC_FAIL;
    offset_res = '0;
    if (ch_ok) begin
      offset_res = s1_crc_ok_r ? offset_sum : offset_cur;
      priority if (!s1_crc_ok_r) begin
        status_c = ST_CRC_FAIL;
      end else if (!tx_match) begin
        status_c = ST_OTHER_TX;
      end else if ({1'b0, seq_id} == last_seq_r) begin
        status_c = ST_DUPLICATE;
      end else begin
        status_c = ST_ACCEPTED;
      end
    end
  end

  // signal strength: halve toward zero, then subtract the offset
  assign sig_ext  = {s1_signal_r[7], s1_signal_r};
  assign sig_half = (sig_ext + $signed({8'd0, s1_signal_r[7]})) >>> 1;
  assign dbm_c    = sig_half - DBM_OFFSET;

  // reading decode
  spfd_unpack u_unpack (
    .raw_code       (s1_raw_code_r),
    .filtered_code  (s1_fil_code_r),
    .raw_value      (raw_dec),
    .filtered_value (fil_dec)
  );

  // channel offsets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        offset_r[i] <= (i < 4) ? OFFSET_SEED[i[1:0]] : 8'd0;
      end
    end else if (upd && ch_ok && s1_crc_ok_r) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        if (5'(i) == {3'd0, s1_channel_r}) begin
          offset_r[i] <= offset_sum;
        end
      end
    end
  end

  // last accepted id
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_seq_r <= SEQ_NONE;
    end else if (upd && status_c == ST_ACCEPTED) begin
      last_seq_r <= {1'b0, seq_id};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
    if (upd) begin
      out_status_r  <= status_c;
      out_offset_r  <= offset_res;
      out_raw_r     <= raw_dec;
      out_fil_r     <= fil_dec;
      out_battery_r <= s1_battery_r;
      out_dbm_r     <= dbm_c;
      out_seq_id_r  <= seq_id;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_channel_offset = out_offset_r;
  assign out_raw_value      = out_raw_r;
  assign out_filtered_value = out_fil_r;
  assign out_battery_out    = out_battery_r;
  assign out_signal_dbm     = out_dbm_r;
  assign out_sequence_id    = out_seq_id_r;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_tx_r <= '0;
    end else if (cfg_wr && cfg_paddr[2] == REG_WANTED_TX) begin
      wanted_tx_r <= cfg_pwdata;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_WANTED_TX) ? wanted_tx_r : 32'd0;

  // checks
  `SPFD_ASSERT_NXT(a_accept_sets_last, upd && status_c == ST_ACCEPTED,
    last_seq_r == {1'b0, $past(seq_id)}, "accepted id not stored")
  `SPFD_ASSERT_NXT(a_reject_keeps_last, upd && status_c != ST_ACCEPTED,
    $stable(last_seq_r), "last id changed on a rejected item")
  `SPFD_ASSERT_IMP(a_result_matches_last,
    out_valid_r && (out_status_r == ST_DUPLICATE || out_status_r == ST_ACCEPTED),
    last_seq_r == {1'b0, out_seq_id_r}, "pending result disagrees with last id")
  `SPFD_ASSERT_NXT(a_held_item_kept, s1_valid_r && !advance, s1_valid_r,
    "held input item lost")

endmodule

@@ sv/spfd_unpack.sv @@
// ----------------------------------------------------------------------------
// spfd_unpack
// decodes the two packed readings: byte-wise bit reversal, then a 13-bit
// mantissa shifted left by a 3-bit exponent; filtered reading doubled
// ----------------------------------------------------------------------------
module spfd_unpack
  import spfd_pkg::*;
(
  input  logic [15:0] raw_code,
  input  logic [15:0] filtered_code,
  output logic [19:0] raw_value,
  output logic [20:0] filtered_value
);

  logic [15:0] raw_flip;
  logic [15:0] fil_flip;
  logic [19:0] fil_dec;

  // undo the bit order inside each byte
  assign raw_flip = {flip8(raw_code[15:8]), flip8(raw_code[7:0])};
  assign fil_flip = {flip8(filtered_code[15:8]), flip8(filtered_code[7:0])};

  // mantissa scaled by exponent
  assign raw_value = {7'd0, raw_flip[12:0]} << raw_flip[15:13];
  assign fil_dec   = {7'd0, fil_flip[12:0]} << fil_flip[15:13];

  // filtered reading is reported doubled
  assign filtered_value = {fil_dec, 1'b0};

endmodule
